### rtl/core/sfr_pkg.sv
// Shared types, constants and the arctangent table for the spherical frame rotation core.
// No dependencies; every other file of the block imports this package.
package sfr_pkg;

    localparam int SFR_ANGLE_BITS  = 16;
    localparam int SFR_TRIG_STAGES = 18;
    localparam int SFR_ROW_BITS    = 54;
    localparam int SFR_COEF_BITS   = 18;
    localparam int SFR_ROOT_BITS   = 31;
    localparam int SFR_RAD_BITS    = 62;

    // CORDIC start value 0.60725 in Q2.30.
    localparam logic [31:0] SFR_GAIN_INV = 32'd652032874;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_ROW0 = 2'd0;
    localparam logic [1:0] CFG_ROW1 = 2'd1;
    localparam logic [1:0] CFG_ROW2 = 2'd2;

    localparam logic [SFR_ROW_BITS-1:0] ROW0_RESET = 54'd65536;
    localparam logic [SFR_ROW_BITS-1:0] ROW1_RESET = 54'd65536 << 18;
    localparam logic [SFR_ROW_BITS-1:0] ROW2_RESET = 54'd65536 << 36;

    // Pipeline advance and the valid bit entering a unit.
    typedef struct packed {
        logic en;
        logic vld;
    } stage_ctrl_t;

    // Arctangent of 2^-i in 32-bit turn units.
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            5'd24:   a = 32'd41;
            5'd25:   a = 32'd20;
            5'd26:   a = 32'd10;
            5'd27:   a = 32'd5;
            5'd28:   a = 32'd3;
            5'd29:   a = 32'd1;
            5'd30:   a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

### rtl/core/sfr_sincos.sv
// Two-lane pipelined rotation-mode CORDIC giving sine and cosine of the two input angles.
// Depends on sfr_pkg.
module sfr_sincos #(
    parameter int ANGLE_BITS = 16,
    parameter int STAGES     = 18
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sfr_pkg::stage_ctrl_t      ctrl,
    input  logic [ANGLE_BITS-1:0]     cone,
    input  logic [ANGLE_BITS-1:0]     clock,
    output logic signed [31:0]        sin_out [2],
    output logic signed [31:0]        cos_out [2],
    output logic                      out_vld
);
    import sfr_pkg::*;

    localparam int XW = 36;
    localparam int ZW = 34;
    localparam int SH = 32 - ANGLE_BITS;

    logic [31:0]          th [2];
    logic signed [XW-1:0] x_reg [2][STAGES+1];
    logic signed [XW-1:0] y_reg [2][STAGES+1];
    logic signed [ZW-1:0] z_reg [2][STAGES+1];
    logic                 neg_reg [2][STAGES+1];
    logic                 vld_reg [STAGES+2];

    assign th[0] = 32'(cone) << SH;
    assign th[1] = 32'(clock) << SH;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic        fold;
        logic [31:0] thf;
        logic [31:0] th_q;

        assign th_q = th[l] + 32'h4000_0000;
        assign fold = th_q[31];
        assign thf  = fold ? (th[l] - 32'h8000_0000) : th[l];

        always_ff @(posedge aclk) begin
            if (ctrl.en) begin
                x_reg[l][0]   <= XW'(SFR_GAIN_INV);
                y_reg[l][0]   <= '0;
                z_reg[l][0]   <= {{(ZW-32){thf[31]}}, thf};
                neg_reg[l][0] <= fold;
            end
        end

        for (genvar s = 1; s <= STAGES; s++) begin : g_iter
            always_ff @(posedge aclk) begin
                if (ctrl.en) begin
                    neg_reg[l][s] <= neg_reg[l][s-1];
                    if (z_reg[l][s-1] >= 0) begin
                        x_reg[l][s] <= x_reg[l][s-1] - (y_reg[l][s-1] >>> (s-1));
                        y_reg[l][s] <= y_reg[l][s-1] + (x_reg[l][s-1] >>> (s-1));
                        z_reg[l][s] <= z_reg[l][s-1] - ZW'(atan_entry(5'(s-1)));
                    end else begin
                        x_reg[l][s] <= x_reg[l][s-1] + (y_reg[l][s-1] >>> (s-1));
                        y_reg[l][s] <= y_reg[l][s-1] - (x_reg[l][s-1] >>> (s-1));
                        z_reg[l][s] <= z_reg[l][s-1] + ZW'(atan_entry(5'(s-1)));
                    end
                end
            end
        end

        // Undo the half-turn fold on the way out.
        always_ff @(posedge aclk) begin
            if (ctrl.en) begin
                cos_out[l] <= neg_reg[l][STAGES] ? -32'(x_reg[l][STAGES])
                                                 : 32'(x_reg[l][STAGES]);
                sin_out[l] <= neg_reg[l][STAGES] ? -32'(y_reg[l][STAGES])
                                                 : 32'(y_reg[l][STAGES]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STAGES + 2; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (ctrl.en) begin
            vld_reg[0] <= ctrl.vld;
            for (int i = 1; i < STAGES + 2; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign out_vld = vld_reg[STAGES+1];

endmodule

### rtl/core/sfr_isqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage, with a sideband.
// Depends on sfr_pkg.
module sfr_isqrt #(
    parameter int SB = 1
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sfr_pkg::stage_ctrl_t                  ctrl,
    input  logic [sfr_pkg::SFR_RAD_BITS-1:0]      radicand,
    input  logic [SB-1:0]                         side_in,
    output logic [sfr_pkg::SFR_ROOT_BITS-1:0]     root,
    output logic [SB-1:0]                         side_out,
    output logic                                  out_vld
);
    import sfr_pkg::*;

    localparam int RW = SFR_ROOT_BITS;
    localparam int MW = RW + 3;

    logic [SFR_RAD_BITS-1:0] nb_reg   [RW+1];
    logic [MW-1:0]           rem_reg  [RW+1];
    logic [RW-1:0]           root_reg [RW+1];
    logic [SB-1:0]           side_reg [RW+1];
    logic                    vld_reg  [RW+1];

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            nb_reg[0]   <= radicand;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= RW; k++) begin : g_digit
        logic [MW-1:0] rem_sh;
        logic [MW-1:0] trial;

        assign rem_sh = {rem_reg[k-1][MW-3:0], nb_reg[k-1][SFR_RAD_BITS-1 -: 2]};
        assign trial  = MW'({root_reg[k-1], 2'b01});

        always_ff @(posedge aclk) begin
            if (ctrl.en) begin
                nb_reg[k]   <= nb_reg[k-1] << 2;
                side_reg[k] <= side_reg[k-1];
                if (rem_sh >= trial) begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_reg[k-1][RW-2:0], 1'b1};
                end else begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_reg[k-1][RW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= RW; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (ctrl.en) begin
            vld_reg[0] <= ctrl.vld;
            for (int i = 1; i <= RW; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign root     = root_reg[RW];
    assign side_out = side_reg[RW];
    assign out_vld  = vld_reg[RW];

endmodule

### rtl/core/sfr_atan2.sv
// Two-lane pipelined vectoring-mode CORDIC giving atan2 in 32-bit turn units, with a sideband.
// Depends on sfr_pkg.
module sfr_atan2 #(
    parameter int STAGES = 18,
    parameter int XW     = 40,
    parameter int SB     = 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sfr_pkg::stage_ctrl_t   ctrl,
    input  logic signed [XW-1:0]   y_in [2],
    input  logic signed [XW-1:0]   x_in [2],
    input  logic [SB-1:0]          side_in,
    output logic signed [33:0]     angle [2],
    output logic [SB-1:0]          side_out,
    output logic                   out_vld
);
    import sfr_pkg::*;

    localparam int ZW = 34;

    logic signed [XW-1:0] x_reg [2][STAGES+1];
    logic signed [XW-1:0] y_reg [2][STAGES+1];
    logic signed [ZW-1:0] z_reg [2][STAGES+1];
    logic [SB-1:0]        side_reg [STAGES+1];
    logic                 vld_reg  [STAGES+1];

    for (genvar l = 0; l < 2; l++) begin : g_lane
        // Left half plane: turn by half a turn first.
        always_ff @(posedge aclk) begin
            if (ctrl.en) begin
                if (x_in[l] < 0) begin
                    x_reg[l][0] <= -x_in[l];
                    y_reg[l][0] <= -y_in[l];
                    z_reg[l][0] <= ZW'(34'sd1 <<< 31);
                end else begin
                    x_reg[l][0] <= x_in[l];
                    y_reg[l][0] <= y_in[l];
                    z_reg[l][0] <= '0;
                end
            end
        end

        for (genvar s = 1; s <= STAGES; s++) begin : g_iter
            always_ff @(posedge aclk) begin
                if (ctrl.en) begin
                    if (y_reg[l][s-1] >= 0) begin
                        x_reg[l][s] <= x_reg[l][s-1] + (y_reg[l][s-1] >>> (s-1));
                        y_reg[l][s] <= y_reg[l][s-1] - (x_reg[l][s-1] >>> (s-1));
                        z_reg[l][s] <= z_reg[l][s-1] + ZW'(atan_entry(5'(s-1)));
                    end else begin
                        x_reg[l][s] <= x_reg[l][s-1] - (y_reg[l][s-1] >>> (s-1));
                        y_reg[l][s] <= y_reg[l][s-1] + (x_reg[l][s-1] >>> (s-1));
                        z_reg[l][s] <= z_reg[l][s-1] - ZW'(atan_entry(5'(s-1)));
                    end
                end
            end
        end

        assign angle[l] = z_reg[l][STAGES];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            side_reg[0] <= side_in;
            for (int i = 1; i <= STAGES; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= STAGES; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (ctrl.en) begin
            vld_reg[0] <= ctrl.vld;
            for (int i = 1; i <= STAGES; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign side_out = side_reg[STAGES];
    assign out_vld  = vld_reg[STAGES];

endmodule

### rtl/core/spherical_frame_rotation_core.sv
// Spherical frame rotation: cone/clock angles to unit vector, 3x3 matrix, back to angles.
// Throughput: one transfer per cycle; every stage is a register and the pipeline only
// halts when a result waits in the output register and m_ready is low.
// Reset (aresetn, synchronous, active low) clears all valid bits and loads the identity.
// Depends on sfr_pkg, sfr_sincos, sfr_isqrt and sfr_atan2.
module spherical_frame_rotation_core #(
    parameter int ANGLE_BITS  = sfr_pkg::SFR_ANGLE_BITS,
    parameter int TRIG_STAGES = sfr_pkg::SFR_TRIG_STAGES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_wen,
    input  logic [1:0]                        cfg_idx,
    input  logic [sfr_pkg::SFR_ROW_BITS-1:0]  cfg_wdata,
    // Input channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ANGLE_BITS-1:0]             s_cone_in,
    input  logic [ANGLE_BITS-1:0]             s_clock_in,
    // Result channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ANGLE_BITS-1:0]             m_cone_out,
    output logic [ANGLE_BITS-1:0]             m_clock_out
);
    import sfr_pkg::*;

    localparam int SH = 32 - ANGLE_BITS;
    localparam int WW = 38;               // width of a rotated component in Q.30
    localparam int XW = 40;               // CORDIC datapath width in the atan2 unit
    localparam int SBW = 1 + 2*WW + 32;   // pole flag, x, y and clamped z
    localparam logic [32:0] HALF_LSB = (33'd1 << SH) >> 1;
    localparam logic [ANGLE_BITS-1:0] HALF_TURN_OUT = ANGLE_BITS'(1) << (ANGLE_BITS-1);

    // The whole pipeline moves as one: it advances whenever the output register is
    // empty or its result is being transferred this cycle.
    logic        en;
    stage_ctrl_t in_ctrl;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign in_ctrl = '{en: en, vld: s_valid};

    // Matrix rows; the user must write them only while the block is idle (not enforced).
    logic [SFR_ROW_BITS-1:0] row_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= ROW0_RESET;
            row_reg[1] <= ROW1_RESET;
            row_reg[2] <= ROW2_RESET;
        end else if (cfg_wen) begin
            case (cfg_idx)
                CFG_ROW0: row_reg[0] <= cfg_wdata;
                CFG_ROW1: row_reg[1] <= cfg_wdata;
                CFG_ROW2: row_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sine and cosine of both angles; lane 0 is the cone, lane 1 the clock.
    logic signed [31:0] sin_v [2];
    logic signed [31:0] cos_v [2];
    logic               trig_vld;

    sfr_sincos #(
        .ANGLE_BITS (ANGLE_BITS),
        .STAGES     (TRIG_STAGES)
    ) u_sincos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (in_ctrl),
        .cone    (s_cone_in),
        .clock   (s_clock_in),
        .sin_out (sin_v),
        .cos_out (cos_v),
        .out_vld (trig_vld)
    );

    // Stage P1: x and y components as products of two Q2.30 values.
    logic signed [63:0] px_reg, py_reg;
    logic signed [31:0] pz_reg;
    // Stage P2: the nine matrix products in Q.46.
    logic signed [51:0] prod_reg [3][3];
    logic signed [33:0] vec [3];
    // Stage P3: the rotated vector in Q.30.
    logic signed [WW-1:0] w_reg [3];
    // Stage P4: clamped z and the pole flag.
    logic signed [31:0]   zc4_reg;
    logic signed [WW-1:0] wx4_reg, wy4_reg;
    logic                 pole4_reg;
    // Stage P5: z squared.
    logic signed [63:0]   zsq_reg;
    logic [SBW-1:0]       side5_reg;
    // Stage P6: the radicand 2^60 - z^2.
    logic [SFR_RAD_BITS-1:0] rad_reg;
    logic [SBW-1:0]          side6_reg;

    logic [6:1] vld_reg;

    assign vec[0] = 34'(px_reg >>> 30);
    assign vec[1] = 34'(py_reg >>> 30);
    assign vec[2] = 34'(pz_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= sin_v[0] * cos_v[1];
            py_reg <= sin_v[0] * sin_v[1];
            pz_reg <= cos_v[0];
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        logic signed [53:0] row_sum;

        for (genvar c = 0; c < 3; c++) begin : g_col
            logic signed [SFR_COEF_BITS-1:0] coef;

            assign coef = signed'(row_reg[r][SFR_COEF_BITS*c +: SFR_COEF_BITS]);

            always_ff @(posedge aclk) begin
                if (en) begin
                    prod_reg[r][c] <= coef * vec[c];
                end
            end
        end

        assign row_sum = 54'(prod_reg[r][0]) + 54'(prod_reg[r][1]) + 54'(prod_reg[r][2]);

        always_ff @(posedge aclk) begin
            if (en) begin
                w_reg[r] <= WW'(row_sum >>> 16);
            end
        end
    end

    // Saturate z to the unit range so that acos stays defined.
    logic signed [31:0] zc_next;

    always_comb begin
        if (w_reg[2] > WW'(64'sd1 <<< 30)) begin
            zc_next = 32'sd1 <<< 30;
        end else if (w_reg[2] < -WW'(64'sd1 <<< 30)) begin
            zc_next = -(32'sd1 <<< 30);
        end else begin
            zc_next = 32'(w_reg[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zc4_reg   <= zc_next;
            wx4_reg   <= w_reg[0];
            wy4_reg   <= w_reg[1];
            pole4_reg <= (w_reg[0] == '0) && (w_reg[1] == '0);
            zsq_reg   <= zc4_reg * zc4_reg;
            side5_reg <= {pole4_reg, wy4_reg, wx4_reg, zc4_reg};
            rad_reg   <= SFR_RAD_BITS'((64'sd1 <<< 60) - zsq_reg);
            side6_reg <= side5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[5:1], trig_vld};
        end
    end

    // Sine of the new cone angle as sqrt(1 - z^2).
    stage_ctrl_t             sq_ctrl;
    logic [SFR_ROOT_BITS-1:0] sin_cone;
    logic [SBW-1:0]          side_sq;
    logic                    sq_vld;

    assign sq_ctrl = '{en: en, vld: vld_reg[6]};

    sfr_isqrt #(
        .SB (SBW)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (sq_ctrl),
        .radicand (rad_reg),
        .side_in  (side6_reg),
        .root     (sin_cone),
        .side_out (side_sq),
        .out_vld  (sq_vld)
    );

    // Both angles back: lane 0 atan2(sqrt(1-z^2), z), lane 1 atan2(y, x).
    stage_ctrl_t          at_ctrl;
    logic signed [XW-1:0] at_y [2];
    logic signed [XW-1:0] at_x [2];
    logic signed [33:0]   at_ang [2];
    logic                 pole_at;
    logic                 at_vld;

    assign at_ctrl = '{en: en, vld: sq_vld};
    assign at_y[0] = XW'({1'b0, sin_cone});
    assign at_x[0] = XW'(signed'(side_sq[31:0]));
    assign at_x[1] = XW'(signed'(side_sq[32 +: WW]));
    assign at_y[1] = XW'(signed'(side_sq[32+WW +: WW]));

    sfr_atan2 #(
        .STAGES (TRIG_STAGES),
        .XW     (XW),
        .SB     (1)
    ) u_atan2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (at_ctrl),
        .y_in     (at_y),
        .x_in     (at_x),
        .side_in  (side_sq[SBW-1]),
        .angle    (at_ang),
        .side_out (pole_at),
        .out_vld  (at_vld)
    );

    // Cone angle is held to [0, half turn]; both angles are rounded half up to
    // ANGLE_BITS, and a clock angle that rounds to a full turn wraps to zero.
    logic [31:0] cone_u;
    logic [32:0] cone_rnd;
    logic [32:0] clock_rnd;

    always_comb begin
        if (at_ang[0] < 0) begin
            cone_u = '0;
        end else if (at_ang[0] > (34'sd1 <<< 31)) begin
            cone_u = 32'h8000_0000;
        end else begin
            cone_u = at_ang[0][31:0];
        end
    end

    assign cone_rnd  = ({1'b0, cone_u} + HALF_LSB) >> SH;
    assign clock_rnd = ({1'b0, at_ang[1][31:0]} + HALF_LSB) >> SH;

    // Output register: the result waits here until it is transferred.
    logic m_valid_reg, m_valid_next;
    logic [ANGLE_BITS-1:0] cone_out_reg, clock_out_reg;

    assign m_valid_next = en ? at_vld : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cone_out_reg  <= cone_rnd[ANGLE_BITS-1:0];
            clock_out_reg <= pole_at ? '0 : clock_rnd[ANGLE_BITS-1:0];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_cone_out  = cone_out_reg;
    assign m_clock_out = clock_out_reg;

    // The cone result never passes half a turn.
    a_cone_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cone_out <= HALF_TURN_OUT))
        else $error("cone angle above half a turn");

    // A stalled pipeline keeps its last valid bit.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(at_vld))
        else $error("pipeline moved during a stall");

    // An advancing pipeline loads the output register from its last stage.
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |=> (m_valid == $past(at_vld)))
        else $error("output valid does not follow the last stage");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for spherical_frame_rotation_core: a bit-exact fixed-point predictor
// of the CORDIC rotation and randomised valid/ready pacing. Depends on sfr_pkg and the core.
module tb;
    import sfr_pkg::*;

    // Register index with no register behind it; writes to it must be ignored.
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam longint     UNIT_Q30  = 64'sd1 << 30;
    localparam longint     HALF_REV  = 64'sd1 << 31;
    localparam int         DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [15:0] cone;
        logic [15:0] clock;
    } angle_pair_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wen;
    logic [1:0]  cfg_idx;
    logic [SFR_ROW_BITS-1:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_cone_in;
    logic [15:0] s_clock_in;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_cone_out;
    logic [15:0] m_clock_out;

    // Local copy of the matrix rows, kept in step with every configuration write.
    logic [SFR_ROW_BITS-1:0] row_shadow [3];
    // Rotated angles still owed by the core, oldest first.
    angle_pair_t rotated_fifo [$];
    int  mismatch_count;
    // When clear, neither side idles, so the pipeline runs back to back.
    bit  pacing_on;
    int  ready_hold;
    int  rx_gap;

    spherical_frame_rotation_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_idx     (cfg_idx),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cone_in   (s_cone_in),
        .s_clock_in  (s_clock_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cone_out  (m_cone_out),
        .m_clock_out (m_clock_out)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------------------------
    // Fixed-point predictor. Every signed right shift rounds towards minus infinity, which
    // is exactly what >>> does on a signed longint.
    // ---------------------------------------------------------------------------------------

    function automatic longint matrix_coef(input int r, input int c);
        logic [17:0] raw;
        raw = row_shadow[r][18*c +: 18];
        return longint'($signed(raw));
    endfunction

    // CORDIC in rotation mode; the angle is folded into the right half plane first.
    function automatic void cordic_sincos(input logic [31:0] theta, output longint sin_v,
                                          output longint cos_v);
        logic [31:0] th;
        bit     flip;
        longint x, y, z, nx;
        th   = theta;
        flip = 1'b0;
        x    = longint'(SFR_GAIN_INV);
        y    = 0;
        if (((th + 32'h4000_0000) & 32'h8000_0000) != 0) begin
            th   = th - 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(th));
        for (int i = 0; i < SFR_TRIG_STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(atan_entry(i[4:0]));
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(atan_entry(i[4:0]));
            end
            x = nx;
        end
        cos_v = flip ? -x : x;
        sin_v = flip ? -y : y;
    endfunction

    // CORDIC in vectoring mode, giving the angle in 32-bit turn units.
    function automatic longint cordic_atan2(input longint yin, input longint xin);
        longint x, y, z, nx;
        x = xin;
        y = yin;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_REV;
        end
        for (int i = 0; i < SFR_TRIG_STAGES; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(atan_entry(i[4:0]));
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(atan_entry(i[4:0]));
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n_in);
        longint unsigned n, r, b;
        n = n_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Round half up from 32-bit turn units to a 16-bit binary angle.
    function automatic logic [15:0] turn_to_angle(input logic [31:0] u);
        logic [32:0] sum;
        sum = {1'b0, u} + 33'd32768;
        return sum[31:16];
    endfunction

    function automatic angle_pair_t rotate_direction(input logic [15:0] cone,
                                                     input logic [15:0] clock);
        longint sin_cone, cos_cone, sin_clk, cos_clk;
        longint vec [3];
        longint rot [3];
        longint zc, ang;
        longint unsigned root;
        angle_pair_t res;
        cordic_sincos({cone, 16'h0}, sin_cone, cos_cone);
        cordic_sincos({clock, 16'h0}, sin_clk, cos_clk);
        vec[0] = (sin_cone * cos_clk) >>> 30;
        vec[1] = (sin_cone * sin_clk) >>> 30;
        vec[2] = cos_cone;
        for (int r = 0; r < 3; r++)
            rot[r] = (matrix_coef(r, 0) * vec[0] + matrix_coef(r, 1) * vec[1]
                      + matrix_coef(r, 2) * vec[2]) >>> 16;

        // z saturates to the unit range, so a z beyond it pins the cone at 0 or pi.
        zc = rot[2];
        if (zc > UNIT_Q30) zc = UNIT_Q30;
        if (zc < -UNIT_Q30) zc = -UNIT_Q30;
        root = int_sqrt(longint'(UNIT_Q30 * UNIT_Q30 - zc * zc));
        ang  = cordic_atan2(longint'(root), zc);
        if (ang < 0) ang = 0;
        if (ang > HALF_REV) ang = HALF_REV;
        res.cone = turn_to_angle(ang[31:0]);

        // At a pole the clock angle is undefined and reported as zero.
        if (rot[0] == 0 && rot[1] == 0) begin
            res.clock = 16'd0;
        end else begin
            ang = cordic_atan2(rot[1], rot[0]);
            res.clock = turn_to_angle(ang[31:0]);
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------------------------
    // Result side: pacing of m_ready and the checker.
    // ---------------------------------------------------------------------------------------

    // After each transfer a fresh stall length is drawn; m_ready stays low for that long.
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            rx_gap = pacing_on ? $urandom_range(0, 15) : 0;
            m_ready    <= (rx_gap == 0);
            ready_hold <= (rx_gap > 0) ? rx_gap - 1 : 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        angle_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rotated_fifo.size() == 0) begin
                $display("MISMATCH at %0t: result transfer with nothing outstanding",
                         $realtime);
                mismatch_count++;
            end else begin
                want = rotated_fifo.pop_front();
                if (m_cone_out !== want.cone)
                    report_mismatch("cone_out", m_cone_out, want.cone);
                if (m_clock_out !== want.clock)
                    report_mismatch("clock_out", m_clock_out, want.clock);
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // Input side.
    // ---------------------------------------------------------------------------------------

    // Valid is only lowered ahead of a gap, so back-to-back transfers keep it high.
    task automatic send_direction(input logic [15:0] cone, input logic [15:0] clock);
        int gap;
        gap = pacing_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_cone_in  <= cone;
        s_clock_in <= clock;
        do @(posedge aclk); while (!s_ready);
        rotated_fifo = {rotated_fifo, rotate_direction(cone, clock)};
    endtask

    // Lowers valid right after the last transfer, waits for every owed result and then
    // lets the pipeline run empty.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (rotated_fifo.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_row(input logic [1:0] idx, input logic [SFR_ROW_BITS-1:0] value);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        if (idx != CFG_SPARE)
            row_shadow[idx] = value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic load_matrix(input logic [17:0] m [9]);
        write_row(CFG_ROW0, {m[2], m[1], m[0]});
        write_row(CFG_ROW1, {m[5], m[4], m[3]});
        write_row(CFG_ROW2, {m[8], m[7], m[6]});
    endtask

    function automatic logic [SFR_ROW_BITS-1:0] random_row();
        return SFR_ROW_BITS'({$urandom, $urandom});
    endfunction

    // Angle extremes, quadrant boundaries and out-of-range cones on the reset identity.
    task automatic test_identity_extremes();
        logic [15:0] cones [7] = '{16'd0, 16'd1, 16'd16384, 16'd32767, 16'd32768,
                                   16'd49152, 16'hFFFF};
        logic [15:0] clocks [4] = '{16'd0, 16'd16384, 16'd32768, 16'hFFFF};
        pacing_on = 1'b0;
        foreach (cones[i]) send_direction(cones[i], clocks[i % 4]);
        pacing_on = 1'b1;
        foreach (clocks[i]) send_direction(16'd8192, clocks[i]);
        send_direction(16'hAAAA, 16'h5555);
        send_direction(16'h5555, 16'hAAAA);
        drain_pipeline();
    endtask

    // Matrices that are not rotations: zero (pole with z at zero), doubled identity and
    // the coefficient extremes, which drive z into saturation.
    task automatic test_degenerate_matrices();
        logic [17:0] zero_m [9]   = '{default: 18'd0};
        logic [17:0] twice_m [9]  = '{18'h20000 - 18'd1, 18'd0, 18'd0, 18'd0, 18'h1FFFF,
                                      18'd0, 18'd0, 18'd0, 18'h1FFFF};
        logic [17:0] neg_m [9]    = '{18'h20000, 18'd0, 18'd0, 18'd0, 18'h20000, 18'd0,
                                      18'd0, 18'd0, 18'h20000};
        load_matrix(zero_m);
        send_direction(16'd0, 16'd0);
        send_direction(16'd12345, 16'd54321);
        drain_pipeline();
        load_matrix(twice_m);
        send_direction(16'd0, 16'd100);
        send_direction(16'd32768, 16'd200);
        send_direction(16'd4000, 16'd60000);
        drain_pipeline();
        load_matrix(neg_m);
        send_direction(16'd0, 16'd0);
        send_direction(16'd32768, 16'd0);
        send_direction(16'd20000, 16'd40000);
        drain_pipeline();
        // A write to the spare index must leave the matrix untouched.
        write_row(CFG_SPARE, {SFR_ROW_BITS{1'b1}});
        send_direction(16'd9000, 16'd30000);
        drain_pipeline();
    endtask

    // Random directions under a series of matrices: the identity, a quarter turn about z
    // by swapping and negating columns, a cyclic permutation of the axes, and fully random rows.
    task automatic test_random_rotations();
        logic [17:0] perm_m [9] = '{18'd0, 18'h10000, 18'd0, 18'h30000, 18'd0, 18'd0,
                                    18'd0, 18'd0, 18'h10000};
        logic [17:0] cyc_m [9]  = '{18'd0, 18'd0, 18'h10000, 18'h10000, 18'd0, 18'd0,
                                    18'd0, 18'h10000, 18'd0};
        logic [17:0] eye_m [9]  = '{18'h10000, 18'd0, 18'd0, 18'd0, 18'h10000, 18'd0,
                                    18'd0, 18'd0, 18'h10000};
        logic [15:0] cone;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: load_matrix(eye_m);
                1: load_matrix(perm_m);
                2: load_matrix(cyc_m);
                default: begin
                    write_row(CFG_ROW0, random_row());
                    write_row(CFG_ROW1, random_row());
                    write_row(CFG_ROW2, random_row());
                end
            endcase
            pacing_on = (phase != 4);
            for (int n = 0; n < 80; n++) begin
                // Mostly legal cones; some use the full field width.
                cone = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 32768));
                send_direction(cone, 16'($urandom));
            end
            drain_pipeline();
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_wen    = 1'b0;
        cfg_idx    = CFG_ROW0;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_cone_in  = '0;
        s_clock_in = '0;
        m_ready    = 1'b0;
        ready_hold = 0;
        pacing_on  = 1'b1;
        mismatch_count = 0;
        row_shadow[0] = ROW0_RESET;
        row_shadow[1] = ROW1_RESET;
        row_shadow[2] = ROW2_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_identity_extremes();
        test_degenerate_matrices();
        test_random_rotations();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### spherical_frame_rotation_core.f
rtl/core/sfr_pkg.sv
rtl/core/sfr_sincos.sv
rtl/core/sfr_isqrt.sv
rtl/core/sfr_atan2.sv
rtl/core/spherical_frame_rotation_core.sv
sim/tb.sv
